// ----- sv/tensor_mass_operator_apply_macros.svh -----
// Assertion macros for the tensor mass operator block.
// Used by the checker; depends on nothing else.
`ifndef TENSOR_MASS_OPERATOR_APPLY_MACROS_SVH
`define TENSOR_MASS_OPERATOR_APPLY_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TMA_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("tma check failed");

// Consequent must hold in the cycle after the antecedent.
`define TMA_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("tma check failed");

`endif

// ----- sv/tma_pkg.sv -----
// Shared types and constants for the tensor mass operator block.
// No dependencies.
package tma_pkg;

  localparam int IDX_W       = 9;
  localparam int STORE_DEPTH = 512;
  localparam int BASIS_DEPTH = 64;
  localparam int BASIS_AW    = 6;
  localparam int DIM_W       = 4;
  localparam int GIDX_W      = 31;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 4;

  localparam int DEF_MAX_DOFS_1D  = 8;
  localparam int DEF_MAX_QUADS_1D = 8;

  // Item function codes
  localparam logic [2:0] FUNC_LOAD_BASIS  = 3'd0;
  localparam logic [2:0] FUNC_LOAD_DOF    = 3'd1;
  localparam logic [2:0] FUNC_LOAD_WEIGHT = 3'd2;
  localparam logic [2:0] FUNC_COMPUTE     = 3'd3;
  localparam logic [2:0] FUNC_READ        = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DOFS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUADS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP  = 2'd2;

  // Contraction passes
  localparam logic [2:0] PASS_INTERP_X = 3'd0;
  localparam logic [2:0] PASS_INTERP_Y = 3'd1;
  localparam logic [2:0] PASS_INTERP_Z = 3'd2;
  localparam logic [2:0] PASS_PROJ_X   = 3'd3;
  localparam logic [2:0] PASS_PROJ_Y   = 3'd4;
  localparam logic [2:0] PASS_PROJ_Z   = 3'd5;

  typedef struct packed {
    logic [2:0]        func;
    logic [IDX_W-1:0]  index;
    logic signed [31:0] value;
    logic signed [31:0] gather_code;
  } tma_req_t;

  typedef struct packed {
    logic [IDX_W-1:0]  local_index;
    logic [GIDX_W-1:0] global_index;
    logic signed [31:0] result_value;
    logic              saturated;
  } tma_rsp_t;

  typedef struct packed {
    logic [DIM_W-1:0] d;
    logic [DIM_W-1:0] q;
    logic             map;
  } tma_dims_t;

  // Controller to datapath commands
  typedef struct packed {
    logic             mul;
    logic             acc;
    logic             fin;
    logic             wmul;
    logic             wfin;
    logic             wr;
    logic             clr;
    logic [IDX_W-1:0] clr_addr;
    logic [2:0]       pass;
    logic [DIM_W-1:0] a;
    logic [DIM_W-1:0] b;
    logic [DIM_W-1:0] c;
    logic [DIM_W-1:0] k;
  } tma_cmd_t;

endpackage

// ----- sv/tma_ram.sv -----
// Generic single-clock RAM, one write port, one registered read port.
// No dependencies.
module tma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/tma_ctrl.sv -----
// Sequencer for the tensor mass operator: clear sweep and contraction loops.
// Depends on tma_pkg.
module tma_ctrl import tma_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      go,
  input  tma_dims_t dims,
  output tma_cmd_t  cmd,
  output logic      busy
);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_ISSUE = 4'd2;
  localparam logic [3:0] ST_MUL   = 4'd3;
  localparam logic [3:0] ST_ACC   = 4'd4;
  localparam logic [3:0] ST_FIN   = 4'd5;
  localparam logic [3:0] ST_WMUL  = 4'd6;
  localparam logic [3:0] ST_WFIN  = 4'd7;
  localparam logic [3:0] ST_WRITE = 4'd8;

  logic [3:0]       state;
  logic [2:0]       pass;
  logic [DIM_W-1:0] a, b, c, k;
  logic [IDX_W:0]   clr_cnt;
  logic [DIM_W-1:0] na, nb, nc, nk;

  // Loop bounds of each pass
  always_comb begin
    case (pass)
      PASS_INTERP_X: begin na = dims.q; nb = dims.d; nc = dims.d; nk = dims.d; end
      PASS_INTERP_Y: begin na = dims.q; nb = dims.q; nc = dims.d; nk = dims.d; end
      PASS_INTERP_Z: begin na = dims.q; nb = dims.q; nc = dims.q; nk = dims.d; end
      PASS_PROJ_X:   begin na = dims.d; nb = dims.q; nc = dims.q; nk = dims.q; end
      PASS_PROJ_Y:   begin na = dims.d; nb = dims.d; nc = dims.q; nk = dims.q; end
      default:       begin na = dims.d; nb = dims.d; nc = dims.d; nk = dims.q; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      pass    <= PASS_INTERP_X;
      a <= '0; b <= '0; c <= '0; k <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (IDX_W+1)'(STORE_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (go) begin
            state <= ST_ISSUE;
            pass  <= PASS_INTERP_X;
            a <= '0; b <= '0; c <= '0; k <= '0;
          end
        end
        ST_ISSUE: state <= ST_MUL;
        ST_MUL:   state <= ST_ACC;
        ST_ACC: begin
          if (k == nk - 1'b1) begin
            state <= ST_FIN;
          end else begin
            k     <= k + 1'b1;
            state <= ST_ISSUE;
          end
        end
        ST_FIN:  state <= (pass == PASS_INTERP_Z) ? ST_WMUL : ST_WRITE;
        ST_WMUL: state <= ST_WFIN;
        ST_WFIN: state <= ST_WRITE;
        ST_WRITE: begin
          // advance output element, then pass
          k     <= '0;
          state <= ST_ISSUE;
          if (a != na - 1'b1) begin
            a <= a + 1'b1;
          end else begin
            a <= '0;
            if (b != nb - 1'b1) begin
              b <= b + 1'b1;
            end else begin
              b <= '0;
              if (c != nc - 1'b1) begin
                c <= c + 1'b1;
              end else begin
                c <= '0;
                if (pass == PASS_PROJ_Z) begin
                  state <= ST_IDLE;
                end else begin
                  pass <= pass + 1'b1;
                end
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.mul      = (state == ST_MUL);
    cmd.acc      = (state == ST_ACC);
    cmd.fin      = (state == ST_FIN);
    cmd.wmul     = (state == ST_WMUL);
    cmd.wfin     = (state == ST_WFIN);
    cmd.wr       = (state == ST_WRITE);
    cmd.clr      = (state == ST_CLEAR);
    cmd.clr_addr = clr_cnt[IDX_W-1:0];
    cmd.pass     = pass;
    cmd.a        = a;
    cmd.b        = b;
    cmd.c        = c;
    cmd.k        = k;
  end

endmodule

// ----- sv/tma_datapath.sv -----
// Datapath: stores, address generation, multiply-accumulate and saturation.
// Depends on tma_pkg and tma_ram.
module tma_datapath import tma_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      accept,
  input  tma_req_t  req,
  input  tma_dims_t dims,
  input  tma_cmd_t  cmd,
  input  logic      busy,
  output logic      result_valid,
  output tma_rsp_t  rsp
);

  // x + nx*(y + ny*z)
  function automatic logic [IDX_W-1:0] lin3(input logic [DIM_W-1:0] x, y, z, nx, ny);
    logic [11:0] t;
    t = 12'(x) + 12'(nx) * (12'(y) + 12'(ny) * 12'(z));
    return t[IDX_W-1:0];
  endfunction

  // Saturating 64-bit add, returns {overflow, sum}
  function automatic logic [64:0] sat_add(input logic signed [63:0] x, y);
    logic [64:0] s;
    logic [63:0] r;
    s = {x[63], x} + {y[63], y};
    r = s[63:0];
    if (s[64] != s[63]) begin
      r = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return {(s[64] != s[63]), r};
  endfunction

  // Floor shift by 16 and saturate to 32 bits, returns {overflow, value}
  function automatic logic [32:0] fin32(input logic signed [63:0] v);
    logic signed [47:0] s;
    logic               ovf;
    logic [31:0]        r;
    s   = 48'(v >>> 16);
    ovf = (s[47:31] != {17{s[47]}});
    r   = s[31:0];
    if (ovf) begin
      r = s[47] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return {ovf, r};
  endfunction

  logic [7:0]       qd;
  logic [9:0]       d3, q3;
  logic             ld_basis, ld_dof, ld_weight, rd_ok;
  logic [IDX_W-1:0] src_idx, dst_idx;
  logic [DIM_W-1:0] bq, bd;
  logic [7:0]       bprod;
  logic [BASIS_AW-1:0] bidx;

  assign qd = 8'(dims.q) * 8'(dims.d);
  assign d3 = 10'(dims.d) * 10'(dims.d) * 10'(dims.d);
  assign q3 = 10'(dims.q) * 10'(dims.q) * 10'(dims.q);

  // Item decode
  assign ld_basis  = accept && (req.func == FUNC_LOAD_BASIS) && (8'(req.index) < qd)
                     && (req.index[IDX_W-1:BASIS_AW] == '0);
  assign ld_dof    = accept && (req.func == FUNC_LOAD_DOF) && (10'(req.index) < d3);
  assign ld_weight = accept && (req.func == FUNC_LOAD_WEIGHT) && (10'(req.index) < q3);
  assign rd_ok     = accept && (req.func == FUNC_READ) && (10'(req.index) < d3);

  // Address generation per pass
  always_comb begin
    case (cmd.pass)
      PASS_INTERP_X: begin
        src_idx = lin3(cmd.k, cmd.b, cmd.c, dims.d, dims.d);
        dst_idx = lin3(cmd.a, cmd.b, cmd.c, dims.q, dims.d);
        bq = cmd.a; bd = cmd.k;
      end
      PASS_INTERP_Y: begin
        src_idx = lin3(cmd.a, cmd.k, cmd.c, dims.q, dims.d);
        dst_idx = lin3(cmd.a, cmd.b, cmd.c, dims.q, dims.q);
        bq = cmd.b; bd = cmd.k;
      end
      PASS_INTERP_Z: begin
        src_idx = lin3(cmd.a, cmd.b, cmd.k, dims.q, dims.q);
        dst_idx = lin3(cmd.a, cmd.b, cmd.c, dims.q, dims.q);
        bq = cmd.c; bd = cmd.k;
      end
      PASS_PROJ_X: begin
        src_idx = lin3(cmd.k, cmd.b, cmd.c, dims.q, dims.q);
        dst_idx = lin3(cmd.a, cmd.b, cmd.c, dims.d, dims.q);
        bq = cmd.k; bd = cmd.a;
      end
      PASS_PROJ_Y: begin
        src_idx = lin3(cmd.a, cmd.k, cmd.c, dims.d, dims.q);
        dst_idx = lin3(cmd.a, cmd.b, cmd.c, dims.d, dims.d);
        bq = cmd.k; bd = cmd.b;
      end
      default: begin
        src_idx = lin3(cmd.a, cmd.b, cmd.k, dims.d, dims.d);
        dst_idx = lin3(cmd.a, cmd.b, cmd.c, dims.d, dims.d);
        bq = cmd.k; bd = cmd.c;
      end
    endcase
  end

  assign bprod = 8'(bq) * 8'(dims.d) + 8'(bd);
  assign bidx  = bprod[BASIS_AW-1:0];

  // Stores
  logic [31:0]       basis_q, dof_q, weight_q;
  logic [GIDX_W-1:0] gidx_q, gidx_dec;
  logic [32:0]       a_q, b_q;
  logic              sat_q;
  logic signed [31:0] res;
  logic              flag;
  logic              we_a, we_b, we_sat;
  logic [IDX_W-1:0]  b_raddr;

  assign gidx_dec = req.gather_code[31] ? ~req.gather_code[30:0] : req.gather_code[30:0];
  assign we_a     = cmd.wr && !cmd.pass[0];
  assign we_b     = cmd.wr && cmd.pass[0];
  assign we_sat   = cmd.clr || (cmd.wr && (cmd.pass == PASS_PROJ_Z));
  assign b_raddr  = busy ? src_idx : req.index;

  tma_ram #(.WIDTH(32), .DEPTH(BASIS_DEPTH)) u_basis (
    .clk(clk), .we(ld_basis), .waddr(req.index[BASIS_AW-1:0]), .wdata(req.value),
    .raddr(bidx), .rdata(basis_q));

  tma_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_dof (
    .clk(clk), .we(ld_dof), .waddr(req.index), .wdata(req.value),
    .raddr(src_idx), .rdata(dof_q));

  tma_ram #(.WIDTH(GIDX_W), .DEPTH(STORE_DEPTH)) u_gidx (
    .clk(clk), .we(ld_dof), .waddr(req.index), .wdata(gidx_dec),
    .raddr(req.index), .rdata(gidx_q));

  tma_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_weight (
    .clk(clk), .we(ld_weight), .waddr(req.index), .wdata(req.value),
    .raddr(dst_idx), .rdata(weight_q));

  tma_ram #(.WIDTH(33), .DEPTH(STORE_DEPTH)) u_work_a (
    .clk(clk), .we(we_a), .waddr(dst_idx), .wdata({flag, res}),
    .raddr(src_idx), .rdata(a_q));

  tma_ram #(.WIDTH(33), .DEPTH(STORE_DEPTH)) u_work_b (
    .clk(clk), .we(we_b), .waddr(dst_idx), .wdata({flag, res}),
    .raddr(b_raddr), .rdata(b_q));

  tma_ram #(.WIDTH(1), .DEPTH(STORE_DEPTH)) u_sat (
    .clk(clk), .we(we_sat), .waddr(cmd.clr ? cmd.clr_addr : dst_idx),
    .wdata(cmd.clr ? 1'b0 : flag), .raddr(req.index), .rdata(sat_q));

  // Source operand select
  logic signed [31:0] src_val;
  logic               src_mark;
  always_comb begin
    case (cmd.pass)
      PASS_INTERP_X: begin src_val = dof_q; src_mark = 1'b0; end
      PASS_INTERP_Z, PASS_PROJ_Y: begin src_val = b_q[31:0]; src_mark = b_q[32]; end
      default: begin src_val = a_q[31:0]; src_mark = a_q[32]; end
    endcase
  end

  // Multiply-accumulate and finishing
  logic signed [63:0] prod, acc;
  logic [64:0]        acc_sum;
  logic [32:0]        fin_acc, fin_prod;

  assign acc_sum  = sat_add((cmd.k == '0) ? 64'sd0 : acc, prod);
  assign fin_acc  = fin32(acc);
  assign fin_prod = fin32(prod);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= 64'(src_val) * 64'($signed(basis_q));
      flag <= (cmd.k == '0) ? src_mark : (flag | src_mark);
    end
    if (cmd.acc) begin
      acc  <= acc_sum[63:0];
      flag <= flag | acc_sum[64];
    end
    if (cmd.fin) begin
      res  <= fin_acc[31:0];
      flag <= flag | fin_acc[32];
    end
    if (cmd.wmul) begin
      prod <= 64'(res) * 64'($signed(weight_q));
    end
    if (cmd.wfin) begin
      res  <= fin_prod[31:0];
      flag <= flag | fin_prod[32];
    end
  end

  // Read items: result in the cycle after accept
  logic [IDX_W-1:0] rd_idx;
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= rd_ok;
    end
    if (rd_ok) begin
      rd_idx <= req.index;
    end
  end

  always_comb begin
    rsp.local_index  = rd_idx;
    rsp.global_index = dims.map ? gidx_q : GIDX_W'(rd_idx);
    rsp.result_value = b_q[31:0];
    rsp.saturated    = sat_q;
  end

endmodule

// ----- sv/tensor_mass_operator_apply.sv -----
// Top level of the sum-factorized 3D mass operator.
// Depends on tma_pkg, tma_ctrl, tma_datapath, tma_ram.
//
// channel   direction  handshake               payload
// item      in         start && !busy          req (tma_req_t)
// result    out        result_valid strobe     rsp (tma_rsp_t)
// config    in         cfg_valid && cfg_ready  cfg_index, cfg_data
//
// Loads and reads never make the block busy; a read's result strobes the next cycle.
// Compute runs six passes on one shared MAC; for each output element every tap of the
// contraction steps through RAM read, registered multiply and saturating 64-bit
// accumulate, then come finish and write; the weight pass adds a weight multiply and finish.
// After reset a sweep clears all 512 saturation marks with busy high.
// The receiver cannot stall; config is always ready.
module tensor_mass_operator_apply import tma_pkg::*; #(
  parameter int MAX_DOFS_1D  = DEF_MAX_DOFS_1D,
  parameter int MAX_QUADS_1D = DEF_MAX_QUADS_1D
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  tma_req_t              req,
  output logic                  result_valid,
  output tma_rsp_t              rsp,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [DIM_W-1:0] dofs_per_dim, quads_per_dim;
  logic             use_gather_map;
  tma_dims_t        dims;
  tma_cmd_t         cmd;
  logic             accept, go;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dofs_per_dim   <= DIM_W'(4);
      quads_per_dim  <= DIM_W'(5);
      use_gather_map <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DOFS:  dofs_per_dim   <= cfg_data;
        CFG_QUADS: quads_per_dim  <= cfg_data;
        CFG_MAP:   use_gather_map <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamp dimensions to the supported range
  always_comb begin
    dims.d = dofs_per_dim;
    if (dofs_per_dim == '0) dims.d = DIM_W'(1);
    else if (dofs_per_dim > DIM_W'(MAX_DOFS_1D)) dims.d = DIM_W'(MAX_DOFS_1D);
    dims.q = quads_per_dim;
    if (quads_per_dim == '0) dims.q = DIM_W'(1);
    else if (quads_per_dim > DIM_W'(MAX_QUADS_1D)) dims.q = DIM_W'(MAX_QUADS_1D);
    dims.map = use_gather_map;
  end

  assign accept = start && !busy;
  assign go     = accept && (req.func == FUNC_COMPUTE);

  tma_ctrl u_ctrl (
    .clk(clk), .rst(rst), .go(go), .dims(dims), .cmd(cmd), .busy(busy));

  tma_datapath u_dp (
    .clk(clk), .rst(rst), .accept(accept), .req(req), .dims(dims), .cmd(cmd),
    .busy(busy), .result_valid(result_valid), .rsp(rsp));

endmodule

// ----- sv/tma_checker.sv -----
// Port-level checks for the tensor mass operator, bound to the top level.
// Depends on tma_pkg and tensor_mass_operator_apply_macros.svh.
`include "tensor_mass_operator_apply_macros.svh"

module tma_checker import tma_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input tma_req_t req,
  input logic     result_valid,
  input tma_rsp_t rsp
);

  // a result only follows an accepted read item
  `TMA_ASSERT_NOW(a_rsp_from_read, clk, rst, result_valid, $past(start && !busy && req.func == FUNC_READ))
  // result carries the index that was read
  `TMA_ASSERT_NOW(a_rsp_index, clk, rst, result_valid, rsp.local_index == $past(req.index))
  // compute item makes the block busy
  `TMA_ASSERT_NEXT(a_compute_busy, clk, rst, start && !busy && req.func == FUNC_COMPUTE, busy)
  // no result strobes during a compute or the clear sweep
  `TMA_ASSERT_NOW(a_busy_quiet, clk, rst, busy, !result_valid)

endmodule

bind tensor_mass_operator_apply tma_checker u_tma_checker (.*);

// ----- verif/tb_tensor_mass_operator_apply.sv -----
// Testbench for tensor_mass_operator_apply: loads elements, runs the mass operator
// and checks every read result against a predictor of the contraction passes.
// Depends on tma_pkg and the tensor_mass_operator_apply RTL.
`timescale 1ns / 1ps

module tb_tensor_mass_operator_apply;
  import tma_pkg::*;

  localparam int IDLE_LIMIT  = 300000;
  localparam int ITEM_TARGET = 600;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  tma_req_t              req;
  logic                  result_valid;
  tma_rsp_t              rsp;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tensor_mass_operator_apply uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .result_valid(result_valid), .rsp(rsp), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // 12 ns clock
  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  // ---------------- predictor state ----------------
  logic [DIM_W-1:0] dims_d, dims_q;
  logic             map_on;
  int               basis_mem [BASIS_DEPTH];
  int               dof_mem   [STORE_DEPTH];
  logic [30:0]      gidx_mem  [STORE_DEPTH];
  int               weight_mem[STORE_DEPTH];
  int               work_a    [STORE_DEPTH];
  int               work_b    [STORE_DEPTH];
  bit               mark_a    [STORE_DEPTH];
  bit               mark_b    [STORE_DEPTH];
  bit               result_mark[STORE_DEPTH];

  tma_rsp_t pending_results[$];
  int       items_sent;
  int       mismatches;
  bit       failed;
  int       burst_left;
  int       idle_cycles;

  function automatic int clamp_dim(logic [DIM_W-1:0] v, int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // 64-bit accumulate that sticks at the int64 limits
  function automatic longint acc_add(longint a, longint b, inout bit f);
    longint s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      f = 1'b1;
      s = a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    end
    return s;
  endfunction

  // floor shift by 16, then saturate to 32 bits
  function automatic int to_q16(longint v, inout bit f);
    longint s;
    s = v >>> 16;
    if (s > 64'sd2147483647) begin
      f = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (s < -64'sd2147483648) begin
      f = 1'b1;
      return 32'sh8000_0000;
    end
    return int'(s);
  endfunction

  function automatic longint bval(int q, int d, int nd);
    return longint'(basis_mem[(q * nd + d) & (BASIS_DEPTH - 1)]);
  endfunction

  // Six contraction passes of the sum-factorized mass operator
  function automatic void apply_mass_operator();
    int dn, qn, i, u;
    longint acc;
    bit f;
    dn = clamp_dim(dims_d, 8);
    qn = clamp_dim(dims_q, 8);
    // interpolate along x
    for (int c = 0; c < dn; c++) for (int b = 0; b < dn; b++) for (int a = 0; a < qn; a++) begin
      acc = 0; f = 0;
      for (int k = 0; k < dn; k++)
        acc = acc_add(acc, longint'(dof_mem[k + dn * (b + dn * c)]) * bval(a, k, dn), f);
      i = a + qn * (b + dn * c);
      work_a[i] = to_q16(acc, f);
      mark_a[i] = f;
    end
    // interpolate along y
    for (int c = 0; c < dn; c++) for (int b = 0; b < qn; b++) for (int a = 0; a < qn; a++) begin
      acc = 0; f = 0;
      for (int k = 0; k < dn; k++) begin
        i = a + qn * (k + dn * c);
        acc = acc_add(acc, longint'(work_a[i]) * bval(b, k, dn), f);
        if (mark_a[i]) f = 1;
      end
      i = a + qn * (b + qn * c);
      work_b[i] = to_q16(acc, f);
      mark_b[i] = f;
    end
    // interpolate along z, then scale by weight
    for (int c = 0; c < qn; c++) for (int b = 0; b < qn; b++) for (int a = 0; a < qn; a++) begin
      acc = 0; f = 0;
      for (int k = 0; k < dn; k++) begin
        i = a + qn * (b + qn * k);
        acc = acc_add(acc, longint'(work_b[i]) * bval(c, k, dn), f);
        if (mark_b[i]) f = 1;
      end
      u = to_q16(acc, f);
      i = a + qn * (b + qn * c);
      work_a[i] = to_q16(longint'(u) * longint'(weight_mem[i]), f);
      mark_a[i] = f;
    end
    // project along x
    for (int c = 0; c < qn; c++) for (int b = 0; b < qn; b++) for (int a = 0; a < dn; a++) begin
      acc = 0; f = 0;
      for (int k = 0; k < qn; k++) begin
        i = k + qn * (b + qn * c);
        acc = acc_add(acc, longint'(work_a[i]) * bval(k, a, dn), f);
        if (mark_a[i]) f = 1;
      end
      i = a + dn * (b + qn * c);
      work_b[i] = to_q16(acc, f);
      mark_b[i] = f;
    end
    // project along y
    for (int c = 0; c < qn; c++) for (int b = 0; b < dn; b++) for (int a = 0; a < dn; a++) begin
      acc = 0; f = 0;
      for (int k = 0; k < qn; k++) begin
        i = a + dn * (k + qn * c);
        acc = acc_add(acc, longint'(work_b[i]) * bval(k, b, dn), f);
        if (mark_b[i]) f = 1;
      end
      i = a + dn * (b + dn * c);
      work_a[i] = to_q16(acc, f);
      mark_a[i] = f;
    end
    // project along z into the result store
    for (int c = 0; c < dn; c++) for (int b = 0; b < dn; b++) for (int a = 0; a < dn; a++) begin
      acc = 0; f = 0;
      for (int k = 0; k < qn; k++) begin
        i = a + dn * (b + dn * k);
        acc = acc_add(acc, longint'(work_a[i]) * bval(k, c, dn), f);
        if (mark_a[i]) f = 1;
      end
      i = a + dn * (b + dn * c);
      work_b[i] = to_q16(acc, f);
      result_mark[i] = f;
    end
  endfunction

  // Update the predicted state for one accepted item; queue a read result
  function automatic void predict_item(tma_req_t it);
    int dn, qn;
    logic signed [31:0] code;
    tma_rsp_t r;
    dn = clamp_dim(dims_d, 8);
    qn = clamp_dim(dims_q, 8);
    case (it.func)
      FUNC_LOAD_BASIS:
        if (it.index < qn * dn && it.index < BASIS_DEPTH) basis_mem[it.index] = it.value;
      FUNC_LOAD_DOF:
        if (it.index < dn * dn * dn) begin
          dof_mem[it.index] = it.value;
          code = it.gather_code;
          gidx_mem[it.index] = code[31] ? 31'(-32'sd1 - code) : code[30:0];
        end
      FUNC_LOAD_WEIGHT:
        if (it.index < qn * qn * qn) weight_mem[it.index] = it.value;
      FUNC_COMPUTE:
        apply_mass_operator();
      FUNC_READ:
        if (it.index < dn * dn * dn) begin
          r.local_index  = it.index;
          r.global_index = map_on ? gidx_mem[it.index] : 31'(it.index);
          r.result_value = work_b[it.index];
          r.saturated    = result_mark[it.index];
          pending_results.push_back(r);
        end
      default: ;
    endcase
  endfunction

  // ---------------- result checker ----------------
  always @(posedge clk) begin
    tma_rsp_t want;
    if (!rst && result_valid) begin
      if (pending_results.size() == 0) begin
        failed = 1;
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result local_index=%0d value=%h", rsp.local_index,
                   rsp.result_value);
      end else begin
        want = pending_results.pop_front();
        if (rsp.local_index !== want.local_index || rsp.global_index !== want.global_index ||
            rsp.result_value !== want.result_value || rsp.saturated !== want.saturated) begin
          failed = 1;
          mismatches++;
          if (mismatches <= 10)
            $display({"ERROR: result mismatch exp idx=%0d gidx=%0d val=%h sat=%b",
                      " got idx=%0d gidx=%0d val=%h sat=%b"},
                     want.local_index, want.global_index, want.result_value, want.saturated,
                     rsp.local_index, rsp.global_index, rsp.result_value, rsp.saturated);
        end
      end
    end
  end

  // Watchdog: cycles without any handshake
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------- drivers ----------------
  task automatic send_item(logic [2:0] fn, int idx, logic [31:0] val, logic [31:0] code);
    tma_req_t it;
    it.func = fn;
    it.index = idx[IDX_W-1:0];
    it.value = val;
    it.gather_code = code;
    start <= 1'b1;
    req   <= it;
    do @(posedge clk); while (busy);
    predict_item(it);
    items_sent++;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 10);
    end else begin
      burst_left--;
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] ri, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= ri;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (ri)
      CFG_DOFS:  dims_d = data;
      CFG_QUADS: dims_q = data;
      CFG_MAP:   map_on = data[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Drain all results and let the block finish before touching registers
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_value(int mode);
    case (mode)
      0: return 32'($signed($urandom_range(0, 262144)) - 131072);
      1: return $urandom();
      default: return ($urandom_range(0, 1) == 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  // Occasional item the block must ignore or answer with nothing
  task automatic send_noise(int dn, int qn);
    case ($urandom_range(0, 4))
      0: send_item(3'($urandom_range(5, 7)), $urandom_range(0, 511), $urandom(), $urandom());
      1: if (qn * dn <= 511)
           send_item(FUNC_LOAD_BASIS, $urandom_range(qn * dn, 511), $urandom(), $urandom());
      2: if (dn * dn * dn <= 511)
           send_item(FUNC_LOAD_DOF, $urandom_range(dn * dn * dn, 511), $urandom(), $urandom());
      3: if (qn * qn * qn <= 511)
           send_item(FUNC_LOAD_WEIGHT, $urandom_range(qn * qn * qn, 511), $urandom(), $urandom());
      default: if (dn * dn * dn <= 511)
           send_item(FUNC_READ, $urandom_range(dn * dn * dn, 511), $urandom(), $urandom());
    endcase
  endtask

  // Load one full element, compute it and read back every result
  task automatic run_element(int vmode, int noise_pct);
    int dn, qn, nd, reads;
    dn = clamp_dim(dims_d, 8);
    qn = clamp_dim(dims_q, 8);
    nd = dn * dn * dn;
    for (int i = 0; i < qn * dn; i++) begin
      send_item(FUNC_LOAD_BASIS, i, rand_value(vmode), $urandom());
      if ($urandom_range(1, 100) <= noise_pct) send_noise(dn, qn);
    end
    for (int i = 0; i < nd; i++) begin
      send_item(FUNC_LOAD_DOF, i, rand_value(vmode), $urandom());
      if ($urandom_range(1, 100) <= noise_pct) send_noise(dn, qn);
    end
    for (int i = 0; i < qn * qn * qn; i++) begin
      send_item(FUNC_LOAD_WEIGHT, i, rand_value(vmode), $urandom());
      if ($urandom_range(1, 100) <= noise_pct) send_noise(dn, qn);
    end
    send_item(FUNC_COMPUTE, $urandom_range(0, 511), $urandom(), $urandom());
    reads = (nd > 64) ? 64 : nd;
    for (int i = 0; i < nd; i++) send_item(FUNC_READ, i, $urandom(), $urandom());
    for (int i = 0; i < reads / 4; i++) begin
      send_item(FUNC_READ, $urandom_range(0, nd - 1), $urandom(), $urandom());
      if ($urandom_range(1, 100) <= noise_pct) send_noise(dn, qn);
    end
  endtask

  // ---------------- tests ----------------
  // Reset values: four dofs, five quadrature points, gather map on
  task automatic test_reset_config();
    run_element(0, 5);
    wait_idle();
  endtask

  // Zero registers clamp to one; extremes of every field, unknown funcs, bad indexes
  task automatic test_single_point();
    write_reg(CFG_DOFS, 4'd0);
    write_reg(CFG_QUADS, 4'd0);
    write_reg(CFG_MAP, 1'b1);
    send_item(FUNC_LOAD_BASIS, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_item(FUNC_LOAD_BASIS, 511, 32'h1234_5678, 32'h0);
    send_item(FUNC_LOAD_DOF, 0, 32'h8000_0000, 32'h8000_0000);
    send_item(FUNC_LOAD_DOF, 1, 32'h1, 32'h7FFF_FFFF);
    send_item(FUNC_LOAD_WEIGHT, 0, 32'h7FFF_FFFF, 32'h0);
    send_item(FUNC_LOAD_WEIGHT, 256, 32'h0, 32'h0);
    send_item(3'd5, 511, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(3'd6, 0, 32'h0, 32'h0);
    send_item(3'd7, 170, 32'hAAAA_AAAA, 32'h5555_5555);
    send_item(FUNC_COMPUTE, 511, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(FUNC_READ, 0, 32'h0, 32'h0);
    send_item(FUNC_READ, 511, 32'h0, 32'h0);
    send_item(FUNC_LOAD_DOF, 0, 32'h0001_0000, 32'h0);
    send_item(FUNC_LOAD_BASIS, 0, 32'h0001_0000, 32'h0);
    send_item(FUNC_LOAD_WEIGHT, 0, 32'hFFFF_0000, 32'h0);
    send_item(FUNC_COMPUTE, 0, 32'h0, 32'h0);
    send_item(FUNC_READ, 0, 32'h0, 32'h0);
    send_item(FUNC_LOAD_DOF, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_item(FUNC_COMPUTE, 0, 32'h0, 32'h0);
    send_item(FUNC_READ, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_idle();
  endtask

  // Full-scale values drive every stage into saturation
  task automatic test_saturation();
    write_reg(CFG_DOFS, 4'd2);
    write_reg(CFG_QUADS, 4'd3);
    run_element(2, 0);
    run_element(1, 10);
    wait_idle();
  endtask

  // Local index reported when the gather map is off
  task automatic test_map_off();
    write_reg(CFG_MAP, 1'b0);
    write_reg(CFG_DOFS, 4'd3);
    write_reg(CFG_QUADS, 4'd1);
    run_element(0, 10);
    wait_idle();
    write_reg(CFG_MAP, 1'b1);
  endtask

  // Random small elements until the item budget is spent
  task automatic test_random_elements();
    while (items_sent < ITEM_TARGET) begin
      write_reg(CFG_DOFS, 4'($urandom_range(1, 4)));
      write_reg(CFG_QUADS, 4'($urandom_range(1, 4)));
      write_reg(CFG_MAP, 1'($urandom_range(0, 1)));
      run_element(($urandom_range(0, 3) == 0) ? 1 : 0, 10);
      wait_idle();
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    dims_d = 4'd4;
    dims_q = 4'd5;
    map_on = 1'b1;
    items_sent = 0;
    mismatches = 0;
    failed = 0;
    burst_left = 0;
    idle_cycles = 0;
    for (int i = 0; i < STORE_DEPTH; i++) result_mark[i] = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_reset_config();
    test_single_point();
    test_saturation();
    test_map_off();
    test_random_elements();

    repeat (20) @(posedge clk);
    if (!failed && pending_results.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
